@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the console RTL.
// No dependencies; files that check their own logic include this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error(msg);

// Antecedent at one edge implies consequent at the same edge.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ hw/rtl/tcce_pkg.sv @@
// Types and fixed constants of the text console cursor engine.
// No dependencies; used by the sweep unit and the top level.
`timescale 1ns / 1ps

package tcce_pkg;

    // Field widths fixed by the interface
    localparam int CMD_W    = 2;
    localparam int CHAR_W   = 8;
    localparam int IDX_W    = 11;
    localparam int CELL_W   = 16;
    localparam int COLOR_W  = 4;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_BS        = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF        = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR        = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PRINT_MAX = 8'h7F;

    // Register indexes (paddr[2])
    localparam logic REG_FORE = 1'b0;
    localparam logic REG_BACK = 1'b1;

    localparam logic [COLOR_W-1:0] FORE_RESET  = 4'd7;
    localparam logic [COLOR_W-1:0] BACK_RESET  = 4'd0;
    localparam logic [CELL_W-1:0]  RESET_BLANK = 16'h0720;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [CHAR_W-1:0] char_code;
        logic [IDX_W-1:0]  cell_index;
    } t_in_req;

    typedef struct packed {
        logic [IDX_W-1:0]  cursor_index;
        logic [CELL_W-1:0] cell_data;
        logic              scrolled;
    } t_out_rsp;

    // Sequencer to sweep unit
    typedef struct packed {
        logic              start;
        logic              shift;   // 1: scroll up one row, 0: fill every cell
        logic [CELL_W-1:0] fill;
    } t_sweep_ctl;

    // Sweep unit to sequencer
    typedef struct packed {
        logic busy;
        logic draining;
    } t_sweep_stat;

endpackage

@@ hw/rtl/text_console_cursor_engine.sv @@
// Text console cursor engine top level: request sequencer, cursor, registers.
// Depends on tcce_pkg, tcce_ram, tcce_sweep and assert_macros.svh.
//
//  channel   direction  handshake                    payload
//  request   in         i_in_valid / o_in_stall      i_in_req  (tcce_pkg::t_in_req)
//  result    out        o_out_valid / i_out_stall    o_out_rsp (tcce_pkg::t_out_rsp)
//  config    in         psel/penable/pwrite/pready   paddr, pwdata, prdata
//
// Put without scroll and nop: EXEC, then DONE, then the output register; read adds RWAIT.
// The next request is taken back in IDLE, which DONE enters once the output register is free.
// Clear and scroll add a sweep pass: the sweep unit touches one cell per
// cycle through the single write port of the screen RAM.
// After reset o_in_stall stays high while a clearing pass runs.
// A result waits in the output register; the next request is taken meanwhile.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module text_console_cursor_engine #(
    parameter int ROWS     = 25,
    parameter int COLS     = 80,
    parameter int TAB_STOP = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  tcce_pkg::t_in_req                 i_in_req,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output tcce_pkg::t_out_rsp                o_out_rsp,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tcce_pkg::APB_AW-1:0]       paddr,
    input  logic [tcce_pkg::APB_DW-1:0]       pwdata,
    output logic [tcce_pkg::APB_DW-1:0]       prdata,
    output logic                              pready
);

    localparam int NCELLS  = ROWS * COLS;
    localparam int AW      = $clog2(NCELLS);
    localparam int CW      = $clog2(COLS);
    localparam int RW      = $clog2(ROWS);
    localparam int NCW     = $clog2(COLS + TAB_STOP + 1);
    localparam int RNW     = RW + 1;
    localparam int IW      = tcce_pkg::IDX_W;
    localparam int DW      = tcce_pkg::CELL_W;
    localparam int TAB_CNT = (COLS - 1) / TAB_STOP + 1;

    localparam logic [2:0] S_BOOT  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_EXEC  = 3'd2;
    localparam logic [2:0] S_RWAIT = 3'd3;
    localparam logic [2:0] S_SWEEP = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]                     r_state, n_state;
    logic [CW-1:0]                  r_col, n_col;
    logic [RW-1:0]                  r_row, n_row;
    logic [tcce_pkg::COLOR_W-1:0]   r_fore, r_back;
    logic [tcce_pkg::CMD_W-1:0]     r_cmd;
    logic [tcce_pkg::CHAR_W-1:0]    r_char;
    logic [IW-1:0]                  r_idx;
    logic                           r_scr, n_scr;
    logic                           r_rd_ok, n_rd_ok;
    logic [DW-1:0]                  r_data, n_data;
    logic                           r_out_valid;
    tcce_pkg::t_out_rsp             r_out;

    logic                           in_take;
    logic                           out_free;
    logic                           cfg_wr;
    logic                           printable;
    logic                           idx_ok;
    logic [NCW-1:0]                 col_step;
    logic [RNW-1:0]                 row_step;
    logic [AW-1:0]                  cur_pos;
    logic [DW-1:0]                  blank;

    tcce_pkg::t_sweep_ctl           sw_ctl;
    tcce_pkg::t_sweep_stat          sw_stat;
    logic                           sw_act;
    logic                           sw_re, sw_we;
    logic [AW-1:0]                  sw_raddr, sw_waddr;
    logic [DW-1:0]                  sw_wdata;

    logic                           ram_we, ram_re;
    logic [AW-1:0]                  ram_waddr, ram_raddr;
    logic [DW-1:0]                  ram_wdata, ram_rdata;

    // ---------------------------------------------------------------
    // Configuration port
    // ---------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fore <= tcce_pkg::FORE_RESET;
            r_back <= tcce_pkg::BACK_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                tcce_pkg::REG_FORE: r_fore <= pwdata[tcce_pkg::COLOR_W-1:0];
                tcce_pkg::REG_BACK: r_back <= pwdata[tcce_pkg::COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            tcce_pkg::REG_FORE: prdata = {{(tcce_pkg::APB_DW-tcce_pkg::COLOR_W){1'b0}}, r_fore};
            tcce_pkg::REG_BACK: prdata = {{(tcce_pkg::APB_DW-tcce_pkg::COLOR_W){1'b0}}, r_back};
            default:            prdata = '0;
        endcase
    end

    assign blank = {r_back, r_fore, tcce_pkg::CH_SPACE};

    // ---------------------------------------------------------------
    // Cursor arithmetic for a put request
    // ---------------------------------------------------------------
    assign printable = (r_char >= tcce_pkg::CH_SPACE) && (r_char <= tcce_pkg::CH_PRINT_MAX);
    assign idx_ok    = (int'(r_idx) < NCELLS);
    assign cur_pos   = AW'(r_row) * AW'(COLS) + AW'(r_col);

    always_comb begin
        col_step = NCW'(r_col);
        row_step = RNW'(r_row);
        if (r_char == tcce_pkg::CH_BS) begin
            if (r_col != '0) begin
                col_step = NCW'(r_col) - 1'b1;
            end
        end else if (r_char == tcce_pkg::CH_TAB) begin
            // pick the smallest tab stop above the column
            for (int k = TAB_CNT; k >= 1; k--) begin
                if (int'(r_col) < k * TAB_STOP) begin
                    col_step = NCW'(k * TAB_STOP);
                end
            end
        end else if (r_char == tcce_pkg::CH_CR) begin
            col_step = '0;
        end else if (r_char == tcce_pkg::CH_LF) begin
            col_step = '0;
            row_step = RNW'(r_row) + 1'b1;
        end else if (printable) begin
            col_step = NCW'(r_col) + 1'b1;
        end
        // wrap past the last column
        if (col_step >= NCW'(COLS)) begin
            col_step = '0;
            row_step = row_step + 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    assign o_in_stall = (r_state != S_IDLE);
    assign in_take    = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign sw_act     = sw_stat.busy || sw_stat.draining;

    always_comb begin
        n_state     = r_state;
        n_col       = r_col;
        n_row       = r_row;
        n_scr       = r_scr;
        n_rd_ok     = r_rd_ok;
        n_data      = r_data;
        sw_ctl      = '0;
        sw_ctl.fill = blank;
        unique case (r_state)
            S_BOOT: begin
                if (!sw_act) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_take) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_scr   = 1'b0;
                n_data  = '0;
                n_rd_ok = 1'b0;
                n_state = S_DONE;
                case (r_cmd)
                    tcce_pkg::CMD_PUT: begin
                        n_col = CW'(col_step);
                        if (row_step >= RNW'(ROWS)) begin
                            n_row        = RW'(ROWS - 1);
                            n_scr        = 1'b1;
                            sw_ctl.start = 1'b1;
                            sw_ctl.shift = 1'b1;
                            n_state      = S_SWEEP;
                        end else begin
                            n_row = RW'(row_step);
                        end
                    end
                    tcce_pkg::CMD_CLEAR: begin
                        n_col        = '0;
                        n_row        = '0;
                        sw_ctl.start = 1'b1;
                        n_state      = S_SWEEP;
                    end
                    tcce_pkg::CMD_READ: begin
                        n_rd_ok = idx_ok;
                        n_state = S_RWAIT;
                    end
                    default: ;
                endcase
            end
            S_RWAIT: begin
                n_data  = r_rd_ok ? ram_rdata : '0;
                n_state = S_DONE;
            end
            S_SWEEP: begin
                if (!sw_act) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_BOOT;
            r_col       <= '0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
            r_row   <= n_row;
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request latch and per-request scratch
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_cmd  <= i_in_req.cmd;
            r_char <= i_in_req.char_code;
            r_idx  <= i_in_req.cell_index;
        end
        r_scr   <= n_scr;
        r_rd_ok <= n_rd_ok;
        r_data  <= n_data;
        if (r_state == S_DONE && out_free) begin
            r_out.cursor_index <= IW'(cur_pos);
            r_out.cell_data    <= r_data;
            r_out.scrolled     <= r_scr;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;

    // ---------------------------------------------------------------
    // Screen memory and sweep unit
    // ---------------------------------------------------------------
    tcce_sweep #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_sweep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (sw_ctl),
        .o_stat  (sw_stat),
        .o_re    (sw_re),
        .o_raddr (sw_raddr),
        .i_rdata (ram_rdata),
        .o_we    (sw_we),
        .o_waddr (sw_waddr),
        .o_wdata (sw_wdata)
    );

    // Sweep owns the RAM while it runs; otherwise the sequencer does
    always_comb begin
        if (sw_act) begin
            ram_we    = sw_we;
            ram_waddr = sw_waddr;
            ram_wdata = sw_wdata;
            ram_re    = sw_re;
            ram_raddr = sw_raddr;
        end else begin
            ram_we    = (r_state == S_EXEC) && (r_cmd == tcce_pkg::CMD_PUT) && printable;
            ram_waddr = cur_pos;
            ram_wdata = {r_back, r_fore, r_char};
            ram_re    = (r_state == S_EXEC) && (r_cmd == tcce_pkg::CMD_READ) && idx_ok;
            ram_raddr = AW'(r_idx);
        end
    end

    tcce_ram #(
        .WIDTH (DW),
        .DEPTH (NCELLS)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    `ASSERT_ALWAYS(a_cursor_in_range, i_clk, i_rst_n, (int'(r_col) < COLS) && (int'(r_row) < ROWS), "cursor outside the screen")
    `ASSERT_IMPLIES(a_idle_no_sweep, i_clk, i_rst_n, !o_in_stall, !sw_act, "request taken while sweep runs")
    `ASSERT_IMPLIES(a_scroll_last_row, i_clk, i_rst_n, (r_state == S_DONE) && r_scr, int'(r_row) == ROWS - 1, "scroll left cursor off last row")
    `ASSERT_NEXT(a_sweep_starts, i_clk, i_rst_n, sw_ctl.start, sw_stat.busy && (r_state == S_SWEEP), "sweep did not start")

endmodule

@@ hw/rtl/tcce_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module tcce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/tcce_sweep.sv @@
// Sweep unit: walks every cell once, either filling or copying up one row and filling the last.
// Depends on tcce_pkg; drives the screen RAM through the top level.
`timescale 1ns / 1ps

module tcce_sweep #(
    parameter int ROWS = 25,
    parameter int COLS = 80
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  tcce_pkg::t_sweep_ctl                i_ctl,
    output tcce_pkg::t_sweep_stat               o_stat,
    output logic                                o_re,
    output logic [$clog2(ROWS*COLS)-1:0]        o_raddr,
    input  logic [tcce_pkg::CELL_W-1:0]         i_rdata,
    output logic                                o_we,
    output logic [$clog2(ROWS*COLS)-1:0]        o_waddr,
    output logic [tcce_pkg::CELL_W-1:0]         o_wdata
);

    localparam int NCELLS    = ROWS * COLS;
    localparam int AW        = $clog2(NCELLS);
    localparam int SHIFT_END = NCELLS - COLS;

    logic                        r_busy;
    logic                        r_shift;
    logic [tcce_pkg::CELL_W-1:0] r_fill;
    logic [AW-1:0]               r_cnt;
    logic                        r_wv;
    logic [AW-1:0]               r_waddr;
    logic                        r_wsrc;
    logic                        copy_now;

    // Every row but the last takes its data from the row underneath
    assign copy_now = r_busy && r_shift && (r_cnt < AW'(SHIFT_END));

    // Reset starts a fill pass with the power-on blank
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b1;
            r_shift <= 1'b0;
            r_fill  <= tcce_pkg::RESET_BLANK;
            r_cnt   <= '0;
            r_wv    <= 1'b0;
        end else begin
            r_wv <= r_busy;
            if (r_busy) begin
                if (r_cnt == AW'(NCELLS - 1)) begin
                    r_busy <= 1'b0;
                end
                r_cnt <= r_cnt + 1'b1;
            end else if (i_ctl.start) begin
                r_busy  <= 1'b1;
                r_shift <= i_ctl.shift;
                r_fill  <= i_ctl.fill;
                r_cnt   <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_waddr <= r_cnt;
        r_wsrc  <= copy_now;
    end

    assign o_re    = copy_now;
    assign o_raddr = r_cnt + AW'(COLS);
    assign o_we    = r_wv;
    assign o_waddr = r_waddr;
    assign o_wdata = r_wsrc ? i_rdata : r_fill;

    assign o_stat.busy     = r_busy;
    assign o_stat.draining = r_wv;

endmodule

@@ tb/tb_text_console_cursor_engine.sv @@
// Self-checking testbench for the text console cursor engine: predicts every result
// from a cell-accurate screen and cursor copy. Depends on tcce_pkg and the top level RTL.
`timescale 1ns / 1ps

module tb_text_console_cursor_engine;
    import tcce_pkg::*;

    localparam int ROWS        = 25;
    localparam int COLS        = 80;
    localparam int TAB_STOP    = 8;
    localparam int STALL_LIMIT = 20000;

    // Screen and cursor tracker: predicts results and checks them in order.
    class console_tracker #(int N_ROWS = 25, int N_COLS = 80, int TAB_W = 8);
        logic [CELL_W-1:0]  screen [N_ROWS*N_COLS];
        int unsigned        col;
        int unsigned        row;
        logic [COLOR_W-1:0] fore;
        logic [COLOR_W-1:0] back;
        t_out_rsp           pending_rsp [$];
        int unsigned        mismatches;
        int unsigned        results;
        int unsigned        requests;
        int unsigned        reads;
        int unsigned        clears;
        int unsigned        scrolls;

        function new();
            foreach (screen[i]) screen[i] = RESET_BLANK;
            col  = 0;
            row  = 0;
            fore = FORE_RESET;
            back = BACK_RESET;
        endfunction

        function logic [CELL_W-1:0] blank_cell();
            return {back, fore, CH_SPACE};
        endfunction

        function void flag(string what, logic [31:0] want_v, logic [31:0] got_v);
            mismatches++;
            if (mismatches <= 10)
                $display("result %0d: %s expected %0h, got %0h", results, what, want_v, got_v);
        endfunction

        function t_out_rsp advance_console(t_in_req r);
            t_out_rsp rsp;
            rsp = '0;
            case (r.cmd)
                CMD_PUT: begin
                    if (r.char_code == CH_BS) begin
                        if (col > 0) col--;
                    end else if (r.char_code == CH_TAB) begin
                        col = (col / TAB_W + 1) * TAB_W;
                    end else if (r.char_code == CH_CR) begin
                        col = 0;
                    end else if (r.char_code == CH_LF) begin
                        col = 0;
                        row++;
                    end else if (r.char_code >= CH_SPACE && r.char_code <= CH_PRINT_MAX) begin
                        screen[row * N_COLS + col] = {back, fore, r.char_code};
                        col++;
                    end
                    if (col >= N_COLS) begin
                        col = 0;
                        row++;
                    end
                    // Past the last row: shift every row up and blank the bottom one
                    if (row >= N_ROWS) begin
                        for (int i = 0; i + N_COLS < N_ROWS * N_COLS; i++)
                            screen[i] = screen[i + N_COLS];
                        for (int i = (N_ROWS - 1) * N_COLS; i < N_ROWS * N_COLS; i++)
                            screen[i] = blank_cell();
                        row = N_ROWS - 1;
                        rsp.scrolled = 1'b1;
                        scrolls++;
                    end
                end
                CMD_CLEAR: begin
                    foreach (screen[i]) screen[i] = blank_cell();
                    col = 0;
                    row = 0;
                    clears++;
                end
                CMD_READ: begin
                    if (r.cell_index < N_ROWS * N_COLS) rsp.cell_data = screen[r.cell_index];
                    reads++;
                end
                default: ;
            endcase
            rsp.cursor_index = IDX_W'(row * N_COLS + col);
            return rsp;
        endfunction

        function void note_request(t_in_req r);
            requests++;
            pending_rsp.push_back(advance_console(r));
        endfunction

        function void check_result(t_out_rsp got);
            t_out_rsp want;
            if (pending_rsp.size() == 0) begin
                flag("result with nothing pending", 32'd0, 32'(got));
                return;
            end
            want = pending_rsp.pop_front();
            results++;
            if (got.cursor_index !== want.cursor_index)
                flag("cursor_index", 32'(want.cursor_index), 32'(got.cursor_index));
            if (got.cell_data !== want.cell_data)
                flag("cell_data", 32'(want.cell_data), 32'(got.cell_data));
            if (got.scrolled !== want.scrolled)
                flag("scrolled", 32'(want.scrolled), 32'(got.scrolled));
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    t_in_req            i_in_req = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    t_out_rsp           o_out_rsp;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [APB_AW-1:0]  paddr = '0;
    logic [APB_DW-1:0]  pwdata = '0;
    logic [APB_DW-1:0]  prdata;
    logic               pready;

    console_tracker #(ROWS, COLS, TAB_STOP) tracker;
    int unsigned stall_left = 0;
    int unsigned idle_cycles = 0;

    text_console_cursor_engine #(
        .ROWS     (ROWS),
        .COLS     (COLS),
        .TAB_STOP (TAB_STOP)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_rsp   (o_out_rsp),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_in_req make_req(logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] ch,
                                         logic [IDX_W-1:0] idx);
        t_in_req r;
        r.cmd        = cmd;
        r.char_code  = ch;
        r.cell_index = idx;
        return r;
    endfunction

    // Called at a falling edge; returns at the falling edge after the request is taken
    // with valid still high, so the caller makes the next single assignment.
    task automatic send_req(input t_in_req r, input int unsigned gap);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= r;
        do @(posedge i_clk); while (o_in_stall);
        tracker.note_request(r);
        @(negedge i_clk);
    endtask

    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (tracker.pending_rsp.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Write one color register, then read it back in the following transfer.
    task automatic write_color_reg(input logic reg_sel, input logic [COLOR_W-1:0] value);
        logic [APB_DW-1:0] rd;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= APB_DW'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rd = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        if (rd !== APB_DW'(value)) tracker.flag("color register readback", value, rd);
        if (reg_sel == REG_FORE) tracker.fore = value;
        else tracker.back = value;
    endtask

    // Receiver: pick quiet runs and stalls of mixed length at random
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
        end else if ($urandom_range(0, 99) < 50) begin
            i_out_stall <= 1'b0;
            stall_left = $urandom_range(1, 30);
        end else begin
            i_out_stall <= 1'b1;
            stall_left = pick_gap() + 1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) tracker.check_result(o_out_rsp);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("text_console_cursor_engine regression: fail");
            $finish;
        end
    end

    initial begin
        t_in_req            req;
        int unsigned        pick;
        int                 row_pick;
        logic [COLOR_W-1:0] fore_sel;
        logic [COLOR_W-1:0] back_sel;
        bit                 steady;

        tracker = new();
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed pass at reset colors; the clearing pass holds off the first request
        send_req(make_req(CMD_PUT, 8'h48, 11'd0), pick_gap());
        send_req(make_req(CMD_PUT, CH_SPACE, 11'h7FF), pick_gap());
        send_req(make_req(CMD_PUT, CH_PRINT_MAX, 11'd0), pick_gap());
        send_req(make_req(CMD_PUT, 8'h00, 11'h7FF), pick_gap());
        send_req(make_req(CMD_PUT, 8'h1F, 11'd5), pick_gap());
        send_req(make_req(CMD_PUT, 8'h80, 11'd0), pick_gap());
        send_req(make_req(CMD_PUT, 8'hFF, 11'h7FF), pick_gap());
        send_req(make_req(CMD_PUT, CH_BS, 11'd0), pick_gap());
        send_req(make_req(CMD_PUT, CH_CR, 11'd0), pick_gap());
        send_req(make_req(CMD_PUT, CH_BS, 11'd0), pick_gap());
        send_req(make_req(CMD_PUT, CH_TAB, 11'd0), pick_gap());
        send_req(make_req(CMD_PUT, CH_TAB, 11'd0), pick_gap());
        send_req(make_req(CMD_PUT, CH_LF, 11'd0), pick_gap());
        send_req(make_req(CMD_READ, 8'hFF, 11'd0), pick_gap());
        send_req(make_req(CMD_READ, 8'h00, 11'd1), pick_gap());
        send_req(make_req(CMD_READ, 8'h00, 11'd2), pick_gap());
        send_req(make_req(CMD_READ, 8'h00, 11'(ROWS * COLS - 1)), pick_gap());
        send_req(make_req(CMD_READ, 8'h00, 11'(ROWS * COLS)), pick_gap());
        send_req(make_req(CMD_READ, 8'h00, 11'h7FF), pick_gap());
        send_req(make_req(CMD_NOP, 8'hFF, 11'h7FF), pick_gap());
        send_req(make_req(CMD_CLEAR, 8'h41, 11'd3), pick_gap());
        send_req(make_req(CMD_READ, 8'h00, 11'd0), pick_gap());
        wait_for_results();

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin fore_sel = 4'hF; back_sel = 4'hF; end
                1: begin fore_sel = 4'h0; back_sel = 4'h0; end
                2: begin fore_sel = 4'hF; back_sel = 4'h0; end
                3: begin fore_sel = 4'h0; back_sel = 4'hF; end
                default: begin
                    fore_sel = COLOR_W'($urandom_range(0, 15));
                    back_sel = COLOR_W'($urandom_range(0, 15));
                end
            endcase
            write_color_reg(REG_FORE, fore_sel);
            write_color_reg(REG_BACK, back_sel);
            steady = ($urandom_range(0, 3) == 0);

            for (int n = 0; n < 96; n++) begin
                pick = $urandom_range(0, 99);
                req = make_req(CMD_PUT, CHAR_W'($urandom_range(0, 255)),
                               IDX_W'($urandom_range(0, 2047)));
                if (pick == 0) begin
                    req.cmd = CMD_CLEAR;
                end else if (pick < 3) begin
                    req.cmd = CMD_NOP;
                end else if (pick < 15) begin
                    req.cmd = CMD_READ;
                    // Mostly read around the cursor, where cells were just written
                    if ($urandom_range(0, 3) != 0) begin
                        row_pick = int'(tracker.row) - int'($urandom_range(0, 2));
                        if (row_pick < 0) row_pick = 0;
                        req.cell_index = IDX_W'(row_pick * COLS + $urandom_range(0, COLS - 1));
                    end
                end else if (pick < 30) begin
                    req.char_code = CH_LF;
                end else if (pick < 35) begin
                    req.char_code = CH_TAB;
                end else if (pick < 39) begin
                    req.char_code = CH_BS;
                end else if (pick < 42) begin
                    req.char_code = CH_CR;
                end else if (pick >= 50) begin
                    req.char_code = CHAR_W'($urandom_range(CH_SPACE, CH_PRINT_MAX));
                end
                send_req(req, steady ? 0 : pick_gap());
                if ($urandom_range(0, 49) == 0) wait_for_results();
            end
            wait_for_results();
        end

        repeat (ROWS * COLS + 20) @(posedge i_clk);
        if (tracker.pending_rsp.size() != 0)
            tracker.flag("results never produced", tracker.pending_rsp.size(), 0);

        $display("Covered %0d requests: %0d reads, %0d clears, %0d scrolls.",
                 tracker.requests, tracker.reads, tracker.clears, tracker.scrolls);
        $display("Ran reset colors plus five color settings; %0d results checked, %0d mismatches.",
                 tracker.results, tracker.mismatches);
        if (tracker.mismatches == 0) begin
            $display("text_console_cursor_engine regression: pass");
        end else begin
            $display("text_console_cursor_engine regression: fail");
        end
        $finish;
    end

endmodule
